/* src/fcct_pkg.sv */
`default_nettype none

package fcct_pkg;

    // Counter width; the time constant and down counter carry one more bit for the full count.
    localparam int COUNT_WIDTH = 8;
    localparam int K_W         = COUNT_WIDTH + 1;
    // Counts fed to a channel in one step never exceed one 8-bit amount.
    localparam int N_W         = 8;
    localparam int CMP_W       = (K_W > N_W) ? K_W : N_W;
    localparam int STEP_W      = $clog2(N_W);
    localparam int NUM_CH      = 4;
    localparam int CH_W        = 2;

    localparam logic [K_W-1:0] K_MASK = K_W'((32'd1 << COUNT_WIDTH) - 32'd1);
    localparam logic [K_W-1:0] K_FULL = K_W'(32'd1 << COUNT_WIDTH);

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_TICK  = 3'd2;
    localparam logic [2:0] KIND_TRIG  = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;

    localparam logic [CH_W-1:0] CHAN_CHAIN = 2'd2;
    localparam logic [CH_W-1:0] CHAN_LAST  = 2'd3;

    // Control word bit positions
    localparam int CW_IE    = 7;
    localparam int CW_CNT   = 6;
    localparam int CW_PS256 = 5;
    localparam int CW_EXT   = 3;
    localparam int CW_TCF   = 2;
    localparam int CW_RST   = 1;
    localparam int CW_CTRL  = 0;

    localparam logic [7:0] VEC_MASK = 8'hF8;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] chan;
        logic [7:0] wdata;
        logic [7:0] amount;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_any;
    } t_out;

    typedef struct packed {
        logic run;
        logic tcw;
        logic ext;
        logic cnt;
        logic ie;
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRITE,
        OP_READ,
        OP_ACK,
        OP_TICK_PRESC,
        OP_PULSE,
        OP_CHAIN,
        OP_CD_CHECK,
        OP_DIV_STEP,
        OP_CD_FIN,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op            op;
        logic [CH_W-1:0] chan;
    } t_cmd;

    typedef struct packed {
        logic [2:0]      kind;
        logic [CH_W-1:0] chan;
        logic            cd_div;
        logic            tc_nz;
        logic            out_free;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK_CH,
        S_CD_CHECK,
        S_DIV,
        S_CD_FIN,
        S_AFTER_CD,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

/* src/fcct_ctrl.sv */
`default_nettype none

module fcct_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire fcct_pkg::t_stat i_stat,
    output fcct_pkg::t_cmd       o_cmd,
    output logic                 o_in_stall
);

    fcct_pkg::t_state               r_state, n_state;
    logic [fcct_pkg::CH_W-1:0]      r_chan, n_chan;
    logic                           r_tick, n_tick;
    logic                           r_chain, n_chain;
    logic [fcct_pkg::STEP_W-1:0]    r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcct_pkg::S_IDLE;
            r_chan  <= '0;
            r_tick  <= 1'b0;
            r_chain <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
            r_tick  <= n_tick;
            r_chain <= n_chain;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        n_tick      = r_tick;
        n_chain     = r_chain;
        n_step      = r_step;
        o_cmd.op    = fcct_pkg::OP_NONE;
        o_cmd.chan  = r_chan;
        o_in_stall  = 1'b1;

        unique case (r_state)
            fcct_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = fcct_pkg::OP_LOAD;
                    n_tick   = 1'b0;
                    n_chain  = 1'b0;
                    n_state  = fcct_pkg::S_DISPATCH;
                end
            end
            fcct_pkg::S_DISPATCH: begin
                o_cmd.chan = i_stat.chan;
                unique case (i_stat.kind)
                    fcct_pkg::KIND_WRITE: begin
                        o_cmd.op = fcct_pkg::OP_WRITE;
                        n_state  = fcct_pkg::S_FINISH;
                    end
                    fcct_pkg::KIND_READ: begin
                        o_cmd.op = fcct_pkg::OP_READ;
                        n_state  = fcct_pkg::S_FINISH;
                    end
                    fcct_pkg::KIND_ACK: begin
                        o_cmd.op = fcct_pkg::OP_ACK;
                        n_state  = fcct_pkg::S_FINISH;
                    end
                    fcct_pkg::KIND_TRIG: begin
                        o_cmd.op = fcct_pkg::OP_PULSE;
                        n_chan   = i_stat.chan;
                        n_state  = fcct_pkg::S_CD_CHECK;
                    end
                    fcct_pkg::KIND_TICK: begin
                        n_chan  = '0;
                        n_tick  = 1'b1;
                        n_state = fcct_pkg::S_TICK_CH;
                    end
                    default: n_state = fcct_pkg::S_FINISH;
                endcase
            end
            fcct_pkg::S_TICK_CH: begin
                o_cmd.op = fcct_pkg::OP_TICK_PRESC;
                n_state  = fcct_pkg::S_CD_CHECK;
            end
            fcct_pkg::S_CD_CHECK: begin
                o_cmd.op = fcct_pkg::OP_CD_CHECK;
                if (i_stat.cd_div) begin
                    n_step  = '0;
                    n_state = fcct_pkg::S_DIV;
                end else begin
                    n_state = fcct_pkg::S_AFTER_CD;
                end
            end
            fcct_pkg::S_DIV: begin
                o_cmd.op = fcct_pkg::OP_DIV_STEP;
                if (r_step == fcct_pkg::STEP_W'(fcct_pkg::N_W - 1)) begin
                    n_state = fcct_pkg::S_CD_FIN;
                end else begin
                    n_step = r_step + fcct_pkg::STEP_W'(1);
                end
            end
            fcct_pkg::S_CD_FIN: begin
                o_cmd.op = fcct_pkg::OP_CD_FIN;
                n_state  = fcct_pkg::S_AFTER_CD;
            end
            fcct_pkg::S_AFTER_CD: begin
                if (r_tick && !r_chain && r_chan == fcct_pkg::CHAN_CHAIN && i_stat.tc_nz) begin
                    // terminal counts of the chained channel clock the last channel
                    o_cmd.op   = fcct_pkg::OP_CHAIN;
                    o_cmd.chan = fcct_pkg::CHAN_LAST;
                    n_chan     = fcct_pkg::CHAN_LAST;
                    n_chain    = 1'b1;
                    n_state    = fcct_pkg::S_CD_CHECK;
                end else if (r_tick && (r_chain || r_chan != fcct_pkg::CHAN_LAST)) begin
                    n_chan  = r_chain ? r_chan : r_chan + 2'd1;
                    n_chain = 1'b0;
                    n_state = fcct_pkg::S_TICK_CH;
                end else begin
                    n_state = fcct_pkg::S_FINISH;
                end
            end
            fcct_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = fcct_pkg::OP_OUT_LOAD;
                    n_state  = fcct_pkg::S_IDLE;
                end
            end
            default: n_state = fcct_pkg::S_IDLE;
        endcase
    end

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcct_pkg::S_DIV) |-> (r_step <= fcct_pkg::STEP_W'(fcct_pkg::N_W - 1)))
        else $error("divider step count out of range");

    a_chain_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chain |-> (r_tick && r_chan == fcct_pkg::CHAN_LAST))
        else $error("chained count outside a tick on the last channel");

endmodule

`default_nettype wire

/* src/fcct_dp.sv */
`default_nettype none

module fcct_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fcct_pkg::t_cmd i_cmd,
    input  wire fcct_pkg::t_in  i_in_data,
    input  wire logic           i_out_stall,
    output fcct_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output fcct_pkg::t_out      o_out_data
);

    // channel state
    logic [fcct_pkg::K_W-1:0] r_dc    [fcct_pkg::NUM_CH];
    logic [fcct_pkg::K_W-1:0] n_dc    [fcct_pkg::NUM_CH];
    logic [fcct_pkg::K_W-1:0] r_k     [fcct_pkg::NUM_CH];
    logic [fcct_pkg::K_W-1:0] n_k     [fcct_pkg::NUM_CH];
    logic [7:0]               r_presc [fcct_pkg::NUM_CH];
    logic [7:0]               n_presc [fcct_pkg::NUM_CH];
    fcct_pkg::t_mode          r_mode  [fcct_pkg::NUM_CH];
    fcct_pkg::t_mode          n_mode  [fcct_pkg::NUM_CH];
    logic [fcct_pkg::NUM_CH-1:0] r_large, n_large;
    logic [fcct_pkg::NUM_CH-1:0] r_irq, n_irq;
    logic [7:0]               r_vec, n_vec;

    // working registers
    fcct_pkg::t_in            r_item, n_item;
    logic [fcct_pkg::N_W-1:0] r_n, n_n;
    logic [fcct_pkg::N_W-1:0] r_quot, n_quot;
    logic [fcct_pkg::K_W-1:0] r_rem, n_rem;
    logic [fcct_pkg::N_W-1:0] r_tc, n_tc;
    logic [7:0]               r_rdata, n_rdata;
    logic                     r_out_valid, n_out_valid;
    fcct_pkg::t_out           r_out, n_out;

    logic [fcct_pkg::CH_W-1:0] c;
    fcct_pkg::t_mode           sel_mode;
    logic [fcct_pkg::K_W-1:0]  sel_k, sel_dc, wm;
    logic [8:0]                acc;
    logic                      cd_go, cd_ge;
    logic [fcct_pkg::CMP_W-1:0] cd_diff;
    logic [fcct_pkg::K_W:0]    div_t;
    logic                      div_bit;
    logic                      ack_hit;
    logic [fcct_pkg::CH_W-1:0] ack_ch;
    logic [fcct_pkg::NUM_CH-1:0] dc_ok;

    assign c        = i_cmd.chan;
    assign sel_mode = r_mode[c];
    assign sel_k    = r_k[c];
    assign sel_dc   = r_dc[c];
    assign acc      = {1'b0, r_presc[c]} + {1'b0, r_item.amount};
    assign wm       = fcct_pkg::K_W'(r_item.wdata) & fcct_pkg::K_MASK;
    assign cd_go    = sel_mode.run && (sel_k != '0) && (r_n != '0);
    assign cd_ge    = fcct_pkg::CMP_W'(r_n) >= fcct_pkg::CMP_W'(sel_dc);
    assign cd_diff  = fcct_pkg::CMP_W'(r_n) - fcct_pkg::CMP_W'(sel_dc);
    assign div_t    = {r_rem, r_quot[fcct_pkg::N_W-1]};
    assign div_bit  = div_t >= {1'b0, sel_k};

    always_comb begin
        ack_hit = 1'b0;
        ack_ch  = '0;
        for (int i = fcct_pkg::NUM_CH - 1; i >= 0; i--) begin
            if (r_irq[i]) begin
                ack_hit = 1'b1;
                ack_ch  = fcct_pkg::CH_W'(i);
            end
        end
    end

    always_comb begin
        n_dc        = r_dc;
        n_k         = r_k;
        n_presc     = r_presc;
        n_mode      = r_mode;
        n_large     = r_large;
        n_irq       = r_irq;
        n_vec       = r_vec;
        n_item      = r_item;
        n_n         = r_n;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_tc        = r_tc;
        n_rdata     = r_rdata;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (i_cmd.op) inside
            fcct_pkg::OP_NONE: begin
            end
            fcct_pkg::OP_LOAD: begin
                n_item  = i_in_data;
                n_rdata = '0;
            end
            fcct_pkg::OP_WRITE: begin
                if (sel_mode.tcw) begin
                    n_mode[c].tcw = 1'b0;
                    n_k[c]        = (wm == '0) ? fcct_pkg::K_FULL : wm;
                    n_dc[c]       = (wm == '0) ? fcct_pkg::K_FULL : wm;
                    n_presc[c]    = '0;
                    n_mode[c].run = sel_mode.cnt || !sel_mode.ext;
                end else if (!r_item.wdata[fcct_pkg::CW_CTRL]) begin
                    if (c == '0) begin
                        n_vec = r_item.wdata & fcct_pkg::VEC_MASK;
                    end
                end else begin
                    n_mode[c].run = sel_mode.run && !r_item.wdata[fcct_pkg::CW_RST];
                    n_mode[c].ie  = r_item.wdata[fcct_pkg::CW_IE];
                    n_mode[c].cnt = r_item.wdata[fcct_pkg::CW_CNT];
                    n_mode[c].ext = r_item.wdata[fcct_pkg::CW_EXT];
                    n_mode[c].tcw = r_item.wdata[fcct_pkg::CW_TCF];
                    n_large[c]    = r_item.wdata[fcct_pkg::CW_PS256];
                    n_irq[c]      = 1'b0;
                    if (r_item.wdata[fcct_pkg::CW_RST]) begin
                        n_presc[c] = '0;
                    end
                end
            end
            fcct_pkg::OP_READ: begin
                n_rdata = 8'(sel_dc);
            end
            fcct_pkg::OP_ACK: begin
                if (ack_hit) begin
                    n_irq[ack_ch] = 1'b0;
                    n_rdata       = r_vec + {5'd0, ack_ch, 1'b0};
                end else begin
                    n_rdata = r_vec;
                end
            end
            fcct_pkg::OP_TICK_PRESC: begin
                if (sel_mode.run && !sel_mode.cnt) begin
                    if (r_large[c]) begin
                        n_presc[c] = acc[7:0];
                        n_n        = fcct_pkg::N_W'(acc >> 8);
                    end else begin
                        n_presc[c] = {4'd0, acc[3:0]};
                        n_n        = fcct_pkg::N_W'(acc >> 4);
                    end
                end else begin
                    n_n = '0;
                end
            end
            fcct_pkg::OP_PULSE, fcct_pkg::OP_CHAIN: begin
                if (sel_mode.cnt) begin
                    n_n = (i_cmd.op == fcct_pkg::OP_CHAIN) ? r_tc
                                                           : fcct_pkg::N_W'(r_item.amount);
                end else begin
                    n_n = '0;
                    // external trigger starts a stopped timer
                    if (sel_mode.ext && !sel_mode.run) begin
                        n_mode[c].run = 1'b1;
                    end
                end
            end
            fcct_pkg::OP_CD_CHECK: begin
                n_tc = '0;
                if (cd_go) begin
                    if (cd_ge) begin
                        n_quot = fcct_pkg::N_W'(cd_diff);
                        n_rem  = '0;
                    end else begin
                        n_dc[c] = sel_dc - fcct_pkg::K_W'(r_n);
                    end
                end
            end
            fcct_pkg::OP_DIV_STEP: begin
                n_rem  = div_bit ? fcct_pkg::K_W'(div_t - {1'b0, sel_k})
                                 : fcct_pkg::K_W'(div_t);
                n_quot = {r_quot[fcct_pkg::N_W-2:0], div_bit};
            end
            fcct_pkg::OP_CD_FIN: begin
                n_dc[c] = sel_k - r_rem;
                n_tc    = r_quot + fcct_pkg::N_W'(1);
                if (sel_mode.ie) begin
                    n_irq[c] = 1'b1;
                end
            end
            fcct_pkg::OP_OUT_LOAD: begin
                n_out.rdata   = r_rdata;
                n_out.irq_any = |r_irq;
                n_out_valid   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fcct_pkg::NUM_CH; i++) begin
                r_dc[i]    <= '0;
                r_k[i]     <= '0;
                r_presc[i] <= '0;
                r_mode[i]  <= '0;
            end
            r_large     <= '0;
            r_irq       <= '0;
            r_vec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dc        <= n_dc;
            r_k         <= n_k;
            r_presc     <= n_presc;
            r_mode      <= n_mode;
            r_large     <= n_large;
            r_irq       <= n_irq;
            r_vec       <= n_vec;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_n     <= n_n;
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_tc    <= n_tc;
        r_rdata <= n_rdata;
        r_out   <= n_out;
    end

    assign o_stat.kind     = r_item.kind;
    assign o_stat.chan     = r_item.chan;
    assign o_stat.cd_div   = cd_go && cd_ge;
    assign o_stat.tc_nz    = r_tc != '0;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    always_comb begin
        for (int i = 0; i < fcct_pkg::NUM_CH; i++) begin
            dc_ok[i] = (r_k[i] == '0) || ((r_dc[i] != '0) && (r_dc[i] <= r_k[i]));
        end
    end

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &dc_ok)
        else $error("loaded counter outside 1..time constant");

    a_ack_clears_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_cmd.op == fcct_pkg::OP_ACK) && (|r_irq))
            |=> ($countones(r_irq) == $countones($past(r_irq)) - 1))
        else $error("acknowledge did not clear exactly one pending flag");

endmodule

`default_nettype wire

/* src/four_channel_counter_timer.sv */
`default_nettype none

// Four-channel counter/timer. Each transfer on the input carries one command (write, counter
// read, tick of the CPU clock, trigger pulses or interrupt acknowledge) and yields exactly one
// result with the read data and the any-pending flag. One command is processed at a time:
// writes, reads, acknowledges and unused kinds go straight to the result, while ticks and
// triggers also run the reload arithmetic, a bit-serial divider that runs once for each
// channel that reaches terminal count; a tick visits each of the four channels in turn
// plus once more for the chained count into channel 3 when channel 2 reaches terminal count.
// A new command is taken while the previous result still waits in the output register.
module four_channel_counter_timer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire fcct_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output fcct_pkg::t_out      o_out_data
);

    fcct_pkg::t_cmd  cmd;
    fcct_pkg::t_stat stat;

    fcct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fcct_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcct_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam logic [7:0] B_IE    = 8'(1 << CW_IE);
    localparam logic [7:0] B_CNT   = 8'(1 << CW_CNT);
    localparam logic [7:0] B_PS256 = 8'(1 << CW_PS256);
    localparam logic [7:0] B_EXT   = 8'(1 << CW_EXT);
    localparam logic [7:0] B_TCF   = 8'(1 << CW_TCF);
    localparam logic [7:0] B_RST   = 8'(1 << CW_RST);
    localparam logic [7:0] B_CTRL  = 8'(1 << CW_CTRL);

    localparam int PRESC_SMALL  = 16;
    localparam int PRESC_LARGE  = 256;
    localparam int RANDOM_ITEMS = 900;
    localparam int MAX_SHOWN    = 10;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    four_channel_counter_timer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #1 i_clk = ~i_clk;

    // Channel state mirrored by the checker
    logic [K_W-1:0] cnt_now     [NUM_CH];
    logic [K_W-1:0] reload      [NUM_CH];
    logic [7:0]     presc_rem   [NUM_CH];
    logic           presc_by256 [NUM_CH];
    t_mode          mode        [NUM_CH];
    logic           pending     [NUM_CH];
    logic [7:0]     vec_base;

    t_in  cmd_q[$];
    t_out due_results[$];

    int n_items, n_sent, n_checked, n_bad, n_served, n_chained;
    int send_gap, send_quiet, hold_left, stall_quiet;

    function automatic int draw_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Count a channel down by n; return how many terminal counts it passed
    function automatic int run_down(int c, int n);
        int k, d, rem, tc;
        k  = reload[c];
        d  = cnt_now[c];
        tc = 0;
        if (!mode[c].run || k == 0 || n == 0) return 0;
        if (n >= d) begin
            rem        = n - d;
            tc         = 1 + rem / k;
            cnt_now[c] = K_W'(k - rem % k);
            if (mode[c].ie) pending[c] = 1'b1;
        end else begin
            cnt_now[c] = K_W'(d - n);
        end
        return tc;
    endfunction

    function automatic void feed_pulses(int c, int n);
        if (mode[c].cnt) begin
            void'(run_down(c, n));
        end else if (mode[c].ext && !mode[c].run) begin
            mode[c].run = 1'b1;
        end
    endfunction

    function automatic void apply_write(int c, logic [7:0] v);
        logic [K_W-1:0] k;
        t_mode nxt;
        if (mode[c].tcw) begin
            k            = K_W'(v) & K_MASK;
            mode[c].tcw  = 1'b0;
            reload[c]    = (k == '0) ? K_FULL : k;
            cnt_now[c]   = reload[c];
            presc_rem[c] = '0;
            mode[c].run  = mode[c].cnt || !mode[c].ext;
            return;
        end
        if (!v[CW_CTRL]) begin
            if (c == 0) vec_base = v & VEC_MASK;
            return;
        end
        nxt            = '0;
        nxt.run        = mode[c].run;
        nxt.ie         = v[CW_IE];
        nxt.cnt        = v[CW_CNT];
        nxt.ext        = v[CW_EXT];
        nxt.tcw        = v[CW_TCF];
        presc_by256[c] = v[CW_PS256];
        pending[c]     = 1'b0;
        if (v[CW_RST]) begin
            nxt.run      = 1'b0;
            presc_rem[c] = '0;
        end
        mode[c] = nxt;
    endfunction

    function automatic void apply_tick(int cycles);
        int acc, t, tc;
        for (int c = 0; c < NUM_CH; c++) begin
            if (!mode[c].run || mode[c].cnt) continue;
            acc = presc_rem[c] + cycles;
            if (presc_by256[c]) begin
                t            = acc / PRESC_LARGE;
                presc_rem[c] = 8'(acc % PRESC_LARGE);
            end else begin
                t            = acc / PRESC_SMALL;
                presc_rem[c] = 8'(acc % PRESC_SMALL);
            end
            tc = run_down(c, t);
            // terminal counts of the chain channel clock the last one in the same tick
            if (c == CHAN_CHAIN && tc != 0) begin
                n_chained += tc;
                feed_pulses(CHAN_LAST, tc);
            end
        end
    endfunction

    function automatic logic [7:0] take_ack();
        for (int c = 0; c < NUM_CH; c++) begin
            if (pending[c]) begin
                pending[c] = 1'b0;
                n_served++;
                return 8'(vec_base + 2 * c);
            end
        end
        return vec_base;
    endfunction

    function automatic t_out ctc_step(t_in it);
        t_out r;
        int   c;
        r = '0;
        c = it.chan;
        case (it.kind)
            KIND_WRITE: apply_write(c, it.wdata);
            KIND_READ:  r.rdata = cnt_now[c][7:0];
            KIND_TICK:  apply_tick(it.amount);
            KIND_TRIG:  feed_pulses(c, it.amount);
            KIND_ACK:   r.rdata = take_ack();
            default:    ;
        endcase
        for (int i = 0; i < NUM_CH; i++) r.irq_any |= pending[i];
        return r;
    endfunction

    task automatic put(logic [2:0] k, logic [1:0] c, logic [7:0] w, logic [7:0] a);
        cmd_q.push_back('{kind: k, chan: c, wdata: w, amount: a});
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                cnt_now[c]     = '0;
                reload[c]      = '0;
                presc_rem[c]   = '0;
                presc_by256[c] = 1'b0;
                mode[c]        = '0;
                pending[c]     = 1'b0;
            end
            vec_base = '0;
        end else begin
            if (in_valid && !in_stall) begin
                due_results.push_back(ctc_step(in_data));
                n_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    in_data  <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap = draw_gap(send_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_checked++;
                if (due_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN)
                        $display("unexpected result: rdata %02h irq_any %0b",
                                 out_data.rdata, out_data.irq_any);
                end else begin
                    want = due_results.pop_front();
                    if (out_data.rdata !== want.rdata || out_data.irq_any !== want.irq_any) begin
                        n_bad++;
                        if (n_bad <= MAX_SHOWN)
                            $display("result %0d: rdata exp %02h got %02h, irq_any exp %0b got %0b",
                                     n_checked, want.rdata, out_data.rdata,
                                     want.irq_any, out_data.irq_any);
                    end
                end
                hold_left = draw_gap(stall_quiet);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            out_stall <= (hold_left > 0);
        end
    end

    initial begin
        int r, ch;
        logic [7:0] cw, tcv, amt;

        // Reset values, then vector handling
        put(KIND_READ,  2'd0, 8'h00, 8'h00);
        put(KIND_ACK,   2'd3, 8'hFF, 8'hFF);
        put(KIND_WRITE, 2'd0, 8'hFE, 8'h00);
        put(KIND_WRITE, 2'd1, 8'h56, 8'h00);
        put(KIND_ACK,   2'd0, 8'h00, 8'h00);
        // Timer, divide by 16, zero constant meaning full count
        put(KIND_WRITE, 2'd0, B_IE | B_TCF | B_RST | B_CTRL, 8'h00);
        put(KIND_WRITE, 2'd0, 8'h00, 8'h00);
        put(KIND_TICK,  2'd0, 8'h00, 8'hFF);
        put(KIND_READ,  2'd0, 8'h00, 8'h00);
        // Chain: channel 2 timer with constant 1 drives channel 3 counter
        put(KIND_WRITE, CHAN_LAST,  B_IE | B_CNT | B_TCF | B_RST | B_CTRL, 8'h00);
        put(KIND_WRITE, CHAN_LAST,  8'h02, 8'h00);
        put(KIND_WRITE, CHAN_CHAIN, B_IE | B_TCF | B_RST | B_CTRL, 8'h00);
        put(KIND_WRITE, CHAN_CHAIN, 8'h01, 8'h00);
        put(KIND_TICK,  2'd0, 8'h00, 8'hFF);
        put(KIND_READ,  CHAN_LAST, 8'h00, 8'h00);
        put(KIND_ACK,   2'd0, 8'h00, 8'h00);
        put(KIND_ACK,   2'd0, 8'h00, 8'h00);
        put(KIND_ACK,   2'd0, 8'h00, 8'h00);
        // External trigger timer started before any constant, then a zero-length trigger
        put(KIND_WRITE, 2'd1, B_EXT | B_PS256 | B_TCF | B_CTRL, 8'h00);
        put(KIND_TRIG,  2'd1, 8'h00, 8'h00);
        put(KIND_TICK,  2'd1, 8'h00, 8'hFF);
        put(KIND_WRITE, 2'd1, 8'hFF, 8'h00);
        put(KIND_TRIG,  2'd1, 8'h00, 8'h00);
        put(KIND_WRITE, 2'd0, 8'hFF, 8'h00);
        put(KIND_TRIG,  2'd0, 8'h00, 8'hFF);
        put(KIND_SPARE_HI, 2'd3, 8'hFF, 8'hFF);

        while (cmd_q.size() < RANDOM_ITEMS + 25) begin
            r   = $urandom_range(0, 99);
            ch  = $urandom_range(0, NUM_CH - 1);
            amt = 8'($urandom);
            if (r < 14) begin
                // control word, usually followed by its constant
                cw = 8'($urandom) | B_CTRL;
                if ($urandom_range(0, 3) != 0) cw |= B_TCF;
                put(KIND_WRITE, 2'(ch), cw, amt);
                if (cw[CW_TCF]) begin
                    tcv = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 12)) : 8'($urandom);
                    put(KIND_WRITE, 2'(ch), tcv, 8'($urandom));
                    if (cw[CW_EXT] && !cw[CW_CNT] && $urandom_range(0, 1) == 1)
                        put(KIND_TRIG, 2'(ch), 8'($urandom), 8'($urandom_range(0, 3)));
                end
            end else if (r < 18) begin
                put(KIND_WRITE, ($urandom_range(0, 2) == 0) ? 2'(ch) : 2'd0,
                    8'($urandom) & ~B_CTRL, amt);
            end else if (r < 21) begin
                put(KIND_WRITE, 2'(ch), 8'($urandom), amt);
            end else if (r < 41) begin
                put(KIND_TICK, 2'(ch), 8'($urandom), amt);
            end else if (r < 55) begin
                if ($urandom_range(0, 3) != 0) amt = 8'($urandom_range(0, 20));
                put(KIND_TRIG, 2'(ch), 8'($urandom), amt);
            end else if (r < 72) begin
                put(KIND_READ, 2'(ch), 8'($urandom), amt);
            end else if (r < 92) begin
                put(KIND_ACK, 2'(ch), 8'($urandom), amt);
            end else begin
                put(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 2'(ch), 8'($urandom), amt);
            end
        end
        n_items = cmd_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_sent == n_items && due_results.size() == 0);
        repeat (100) @(posedge i_clk);

        $display("%0d commands sent, %0d results compared, %0d mismatches",
                 n_sent, n_checked, n_bad);
        $display("%0d acknowledges served a pending channel, %0d chained counts into channel 3",
                 n_served, n_chained);
        if (n_bad == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d of %0d commands sent, %0d results outstanding",
                 n_sent, n_items, due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
